@@ design/mbfd_pkg.sv @@
// Package with the shared types, codes and constants of the box-filter downsampler.
package mbfd_pkg;

  localparam int TEXEL_W    = 32;
  localparam int DIM_W      = 13;
  localparam int HEIGHT_CAP = 4096;
  localparam int ROW_W      = 12;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH   = 2'd0,
    REG_SRC_HEIGHT  = 2'd1,
    REG_PIXEL_FORMAT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FMT_RGBA8    = 3'd0,
    FMT_R5G6B5   = 3'd1,
    FMT_A4R4G4B4 = 3'd2,
    FMT_A1R5G5B5 = 3'd3,
    FMT_R8       = 3'd4
  } pix_fmt_e;

  typedef struct packed {
    logic [TEXEL_W-1:0] top_l;
    logic [TEXEL_W-1:0] top_r;
    logic [TEXEL_W-1:0] bot_l;
    logic [TEXEL_W-1:0] bot_r;
  } quad_t;

endpackage

@@ design/mbfd_if.sv @@
// Stream and configuration interfaces of the box-filter downsampler.
interface mbfd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] texel_in;
  modport source (output valid, output texel_in, input ready);
  modport sink (input valid, input texel_in, output ready);
endinterface

interface mbfd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] texel_out;
  logic        last_of_level;
  modport source (output valid, output texel_out, output last_of_level, input ready);
  modport sink (input valid, input texel_out, input last_of_level, output ready);
endinterface

interface mbfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/mip_box_filter_downsample_top.sv @@
// Top level of the 2x2 box-filter mip level downsampler.
// Parent texels enter in raster order, one per cycle unless the output stalls, and
// each child texel leaves once the texel that completes its quad has passed the
// filter stage, which also registers the line store read, and the output register.
// Even parent rows are kept as texel pairs in a single-port-write line store of
// (MAX_WIDTH+1)/2 entries, read on odd rows; a width or height of one pairs a texel
// with itself, and trailing odd columns and rows are consumed without a result. Any
// register write restarts the level. The line store needs no clearing after reset.
module mip_box_filter_downsample_top
  import mbfd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  mbfd_cfg_if.sink   cfg_i,
  mbfd_in_if.sink    in_i,
  mbfd_out_if.source out_o
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DIM_W-1:0] src_w_q, src_h_q;
  logic [2:0]       fmt_q;
  logic             cfg_fire, cfg_hit;

  logic [XW-1:0]    x_q, x_d, wm1, last_x;
  logic [ROW_W-1:0] y_q, y_d, hm1, last_y;
  logic             w1, h1;

  logic [TEXEL_W-1:0] held_q, left;
  logic               accept, col_done, row_done, has_result;

  logic               mem_we, mem_re;
  logic [63:0]        mem_rdata;

  logic               s1_valid_q, s1_use_top_q, s1_last_q, s1_fire;
  logic [TEXEL_W-1:0] s1_left_q, s1_right_q;
  quad_t              quad;
  logic [TEXEL_W-1:0] filtered;

  logic               out_valid_q, out_last_q;
  logic [TEXEL_W-1:0] out_texel_q;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign cfg_hit     = cfg_fire && (cfg_i.index == REG_SRC_WIDTH ||
                                    cfg_i.index == REG_SRC_HEIGHT ||
                                    cfg_i.index == REG_PIXEL_FORMAT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DIM_W'(1);
      src_h_q <= DIM_W'(1);
      fmt_q   <= FMT_RGBA8;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_SRC_WIDTH:    src_w_q <= cfg_i.data;
        REG_SRC_HEIGHT:   src_h_q <= cfg_i.data;
        REG_PIXEL_FORMAT: fmt_q   <= cfg_i.data[2:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions minus one, and the last column and row that complete a quad.
  always_comb begin
    if (src_w_q == '0) begin
      wm1 = '0;
    end else if (32'(src_w_q) > 32'(MAX_WIDTH)) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(src_w_q - DIM_W'(1));
    end
    if (src_h_q == '0) begin
      hm1 = '0;
    end else if (src_h_q > DIM_W'(HEIGHT_CAP)) begin
      hm1 = ROW_W'(HEIGHT_CAP - 1);
    end else begin
      hm1 = ROW_W'(src_h_q - DIM_W'(1));
    end
    w1     = (wm1 == '0);
    h1     = (hm1 == '0);
    last_x = w1 ? '0 : (wm1[0] ? wm1 : wm1 - XW'(1));
    last_y = h1 ? '0 : (hm1[0] ? hm1 : hm1 - ROW_W'(1));
  end

  // Input side: position walk and line store access.
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign accept     = in_i.valid && in_i.ready;

  assign col_done   = w1 || x_q[0];
  assign row_done   = h1 || y_q[0];
  assign has_result = col_done && row_done;
  assign left       = w1 ? in_i.texel_in : held_q;

  assign mem_we = accept && !h1 && !y_q[0] && (w1 || x_q[0]);
  assign mem_re = accept && !h1 && y_q[0] && has_result;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (cfg_hit) begin
      x_d = '0;
      y_d = '0;
    end else if (accept) begin
      if (x_q == wm1) begin
        x_d = '0;
        y_d = (y_q == hm1) ? '0 : y_q + ROW_W'(1);
      end else begin
        x_d = x_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      held_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      if (accept && !x_q[0]) begin
        held_q <= in_i.texel_in;
      end
    end
  end

  mbfd_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(x_q >> 1)),
    .wdata_i ({in_i.texel_in, left}),
    .re_i    (mem_re),
    .raddr_i (AW'(x_q >> 1)),
    .rdata_o (mem_rdata)
  );

  // Filter stage, waiting on the line store read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept && has_result) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_result) begin
      s1_left_q    <= left;
      s1_right_q   <= in_i.texel_in;
      s1_use_top_q <= !h1;
      s1_last_q    <= (x_q == last_x) && (y_q == last_y);
    end
  end

  always_comb begin
    quad.top_l = s1_use_top_q ? mem_rdata[31:0] : s1_left_q;
    quad.top_r = s1_use_top_q ? mem_rdata[63:32] : s1_right_q;
    quad.bot_l = s1_left_q;
    quad.bot_r = s1_right_q;
  end

  mbfd_quad_filter u_quad_filter (
    .fmt_i   (fmt_q),
    .quad_i  (quad),
    .texel_o (filtered)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_texel_q <= filtered;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.texel_out     = out_texel_q;
  assign out_o.last_of_level = out_last_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("line store read and write in the same cycle");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && has_result && (x_q == last_x) && (y_q == last_y) && !cfg_hit &&
     (x_q == wm1) && (y_q == hm1)) |=> (x_q == '0 && y_q == '0))
    else $error("position did not return to the start after the last texel");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (x_q == '0 && y_q == '0))
    else $error("register write did not restart the level");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |=> s1_valid_q)
    else $error("filter stage lost its item while the output stalled");

endmodule

@@ design/mbfd_line_store.sv @@
// Line store holding texel pairs of the last even parent row.
module mbfd_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/mbfd_quad_filter.sv @@
// Per-format rounded average of a 2x2 quad of texels.
module mbfd_quad_filter
  import mbfd_pkg::*;
(
  input  logic [2:0]  fmt_i,
  input  quad_t       quad_i,
  output logic [31:0] texel_o
);

  function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d);
    logic [9:0] s;
    s = 10'(a) + 10'(b) + 10'(c) + 10'(d) + 10'd2;
    return s[9:2];
  endfunction

  function automatic logic [5:0] avg6(input logic [5:0] a, input logic [5:0] b,
                                      input logic [5:0] c, input logic [5:0] d);
    logic [7:0] s;
    s = 8'(a) + 8'(b) + 8'(c) + 8'(d) + 8'd2;
    return s[7:2];
  endfunction

  function automatic logic [4:0] avg5(input logic [4:0] a, input logic [4:0] b,
                                      input logic [4:0] c, input logic [4:0] d);
    logic [6:0] s;
    s = 7'(a) + 7'(b) + 7'(c) + 7'(d) + 7'd2;
    return s[6:2];
  endfunction

  function automatic logic [3:0] avg4(input logic [3:0] a, input logic [3:0] b,
                                      input logic [3:0] c, input logic [3:0] d);
    logic [5:0] s;
    s = 6'(a) + 6'(b) + 6'(c) + 6'(d) + 6'd2;
    return s[5:2];
  endfunction

  logic [31:0] a, b, c, d;
  logic [2:0]  votes;

  assign a = quad_i.top_l;
  assign b = quad_i.top_r;
  assign c = quad_i.bot_l;
  assign d = quad_i.bot_r;
  assign votes = 3'(a[15]) + 3'(b[15]) + 3'(c[15]) + 3'(d[15]);

  always_comb begin
    case (fmt_i)
      FMT_R5G6B5: begin
        texel_o = {16'd0, avg5(a[15:11], b[15:11], c[15:11], d[15:11]),
                   avg6(a[10:5], b[10:5], c[10:5], d[10:5]),
                   avg5(a[4:0], b[4:0], c[4:0], d[4:0])};
      end
      FMT_A4R4G4B4: begin
        texel_o = {16'd0, avg4(a[15:12], b[15:12], c[15:12], d[15:12]),
                   avg4(a[11:8], b[11:8], c[11:8], d[11:8]),
                   avg4(a[7:4], b[7:4], c[7:4], d[7:4]),
                   avg4(a[3:0], b[3:0], c[3:0], d[3:0])};
      end
      FMT_A1R5G5B5: begin
        texel_o = {16'd0, (votes >= 3'd2),
                   avg5(a[14:10], b[14:10], c[14:10], d[14:10]),
                   avg5(a[9:5], b[9:5], c[9:5], d[9:5]),
                   avg5(a[4:0], b[4:0], c[4:0], d[4:0])};
      end
      FMT_R8: begin
        texel_o = {24'd0, avg8(a[7:0], b[7:0], c[7:0], d[7:0])};
      end
      default: begin
        texel_o = {avg8(a[31:24], b[31:24], c[31:24], d[31:24]),
                   avg8(a[23:16], b[23:16], c[23:16], d[23:16]),
                   avg8(a[15:8], b[15:8], c[15:8], d[15:8]),
                   avg8(a[7:0], b[7:0], c[7:0], d[7:0])};
      end
    endcase
  end

endmodule
